/* sv/bloom_filter_rolling_hash_core_defines.svh */
// Assertion macros shared by the bloom filter core RTL.
// Each macro assumes clk_i and rst_ni are in scope; no other dependencies.
`ifndef BLOOM_FILTER_ROLLING_HASH_CORE_DEFINES_SVH
`define BLOOM_FILTER_ROLLING_HASH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define BFRH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define BFRH_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BFRH_ASSERT(name, prop, msg)
`define BFRH_ASSERT_NR(name, prop, msg)
`endif
`endif

/* sv/bfrh_pkg.sv */
// Shared types and constants of the bloom filter core.
// No dependencies; used by every module of the block but bfrh_mod.
`default_nettype none

package bfrh_pkg;

  localparam int unsigned MaxBitsDef   = 65536;
  localparam int unsigned TableBitsW   = 17;
  localparam int unsigned TableBitsRst = 65536;
  localparam int unsigned CharW        = 8;
  localparam int unsigned HashMult     = 31;
  // conditional subtractions needed for one character step
  localparam int unsigned StepsChar    = 9;
  localparam int unsigned QueueDepth   = 2;

  // command field of a request
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef enum logic [1:0] {
    OpChar   = 2'd0,
    OpInsert = 2'd1,
    OpQuery  = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] char_code;
  } job_t;

endpackage

`default_nettype wire

/* sv/bloom_filter_rolling_hash_core.sv */
// Top level of the bloom filter core with a rolling polynomial hash.
// Depends on bfrh_pkg, bfrh_front and bfrh_back.
//
// Channel   Dir  Handshake                  Payload
// --------  ---  -------------------------  -----------------------------------------
// cfg       in   cfg_we_i                   cfg_wdata_i: table_bits (hash modulus m)
// s_axis    in   s_axis_tvalid/tready       tdata: char_code, tuser: cmd, tlast: last
// m_axis    out  m_axis_tvalid/tready       tdata[0]: maybe_present, tuser: was_query
//
// After reset the bit store is swept clean, one byte a cycle, through all (MAX_BITS+7)/8
// bytes of the store; no request is taken until the sweep ends.
// A character passes through the back end as start, 9 steps of the shared
// conditional subtractor and writeback; the closing character of a word adds
// a store read, then result load and, for an insert, bit set.
// The first character after a configuration write first waits while the held hash
// is reduced by the new modulus.
// A stalled result holds in the output register; the back end goes on with the next
// word, waiting at its result load, while the two-entry queue takes requests until full.
`default_nettype none

module bloom_filter_rolling_hash_core #(
  parameter int unsigned MAX_BITS    = bfrh_pkg::MaxBitsDef,
  parameter int unsigned QUEUE_DEPTH = bfrh_pkg::QueueDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [bfrh_pkg::TableBitsW-1:0] cfg_wdata_i,    // table_bits
  // character requests
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [7:0]                      s_axis_tdata_i, // [7:0] char_code
  input  wire logic                            s_axis_tuser_i, // [0] cmd
  input  wire logic                            s_axis_tlast_i,
  // results
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [7:0]                           m_axis_tdata_o, // [0] maybe_present
  output logic                                 m_axis_tuser_o  // [0] was_query
);

  localparam int unsigned MW = $clog2(MAX_BITS + 1);
  localparam int unsigned ResetMod = (bfrh_pkg::TableBitsRst > MAX_BITS) ?
                                     MAX_BITS : bfrh_pkg::TableBitsRst;

  // effective modulus: zero reads as one, anything past the store clamps to its size
  logic [MW-1:0]  mod_q, mod_d;
  logic           front_ready, clearing;
  logic           job_valid, job_ready;
  bfrh_pkg::job_t job;
  logic           out_maybe;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      mod_d = MW'(1);
    end else if (32'(cfg_wdata_i) > 32'(MAX_BITS)) begin
      mod_d = MW'(MAX_BITS);
    end else begin
      mod_d = MW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MW'(ResetMod);
    end else if (cfg_we_i) begin
      mod_q <= mod_d;
    end
  end

  // hold off requests until the store sweep is done
  assign s_axis_tready_o = front_ready & ~clearing;

  bfrh_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid_i & ~clearing),
    .in_ready_o (front_ready),
    .in_cmd_i   (s_axis_tuser_i),
    .in_char_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .out_valid_o(job_valid),
    .out_ready_i(job_ready),
    .out_job_o  (job)
  );

  bfrh_back #(
    .MAX_BITS(MAX_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .mod_i      (mod_q),
    .renorm_i   (cfg_we_i),
    .job_valid_i(job_valid),
    .job_ready_o(job_ready),
    .job_i      (job),
    .clearing_o (clearing),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_query_o(m_axis_tuser_o),
    .out_maybe_o(out_maybe)
  );

  assign m_axis_tdata_o = {7'b0, out_maybe};

endmodule

`default_nettype wire

/* sv/bfrh_front.sv */
// Front end: accepts character requests, classifies them and queues them.
// Depends on bfrh_pkg and the assertion macro header.
`default_nettype none
`include "bloom_filter_rolling_hash_core_defines.svh"

module bfrh_front #(
  parameter int unsigned DEPTH = bfrh_pkg::QueueDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       in_cmd_i,
  input  wire logic [bfrh_pkg::CharW-1:0] in_char_i,
  input  wire logic                       in_last_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output bfrh_pkg::job_t                  out_job_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  bfrh_pkg::job_t ent_q [DEPTH];
  bfrh_pkg::job_t job_new;
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            push, pop;

  // only the command on the closing character counts
  always_comb begin
    job_new.char_code = in_char_i;
    if (!in_last_i) begin
      job_new.op = bfrh_pkg::OpChar;
    end else if (in_cmd_i == bfrh_pkg::CmdQuery) begin
      job_new.op = bfrh_pkg::OpQuery;
    end else begin
      job_new.op = bfrh_pkg::OpInsert;
    end
  end

  assign in_ready_o  = (count_q != CNTW'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_job_o   = ent_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= job_new;
    end
  end

  `BFRH_ASSERT(a_count_bound, (count_q <= CNTW'(DEPTH)), "queue count beyond depth")

endmodule

`default_nettype wire

/* sv/bfrh_mod.sv */
// Iterative remainder unit: one conditional subtraction of m<<k per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module bfrh_mod #(
  parameter int unsigned MW = 17,
  parameter int unsigned RW = 33,
  parameter int unsigned KW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [RW-1:0] value_i,
  input  wire logic [KW-1:0] kstart_i,
  input  wire logic [MW-1:0] mod_i,
  output logic               done_o,
  output logic [RW-1:0]      rem_o
);

  logic [RW-1:0] rem_q, rem_d, shifted;
  logic [KW-1:0] k_q, k_d;
  logic          busy_q, busy_d, done_q, done_d;

  assign shifted = RW'(mod_i) << k_q;

  always_comb begin
    rem_d  = rem_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = value_i;
      k_d    = kstart_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= shifted) begin
        rem_d = rem_q - shifted;
      end
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        k_d = k_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* sv/bfrh_back.sv */
// Back end: running hash, bit store with clearing pass, result register.
// Depends on bfrh_pkg, bfrh_mod and the assertion macro header.
`default_nettype none
`include "bloom_filter_rolling_hash_core_defines.svh"

module bfrh_back #(
  parameter int unsigned MAX_BITS = bfrh_pkg::MaxBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [$clog2(MAX_BITS+1)-1:0] mod_i,
  input  wire logic                          renorm_i,
  input  wire logic                          job_valid_i,
  output logic                               job_ready_o,
  input  wire bfrh_pkg::job_t                job_i,
  output logic                               clearing_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               out_query_o,
  output logic                               out_maybe_o
);

  localparam int unsigned MW         = $clog2(MAX_BITS + 1);
  localparam int unsigned HW         = ($clog2(MAX_BITS) < 4) ? 4 : $clog2(MAX_BITS);
  localparam int unsigned BIW        = HW - 3;
  localparam int unsigned StoreBytes = (MAX_BITS + 7) / 8;
  localparam int unsigned KMax       = ((HW - 1) > (bfrh_pkg::StepsChar - 1)) ?
                                       (HW - 1) : (bfrh_pkg::StepsChar - 1);
  localparam int unsigned KW         = $clog2(KMax + 1);
  localparam int unsigned RW         = MW + KMax + 1;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_RENORM = 6'b000100,
    ST_HASH   = 6'b001000,
    ST_READ   = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  logic [HW-1:0]  hash_q, hash_d;
  bfrh_pkg::op_e  op_q, op_d;
  logic           renorm_q, renorm_d;
  logic [BIW-1:0] clr_cnt_q, clr_cnt_d;
  logic [BIW-1:0] idx_q, idx_d;
  logic [2:0]     sel_q, sel_d;
  logic [7:0]     rd_q;
  logic           out_valid_q, out_valid_d;
  logic           out_query_q, out_query_d;
  logic           out_maybe_q, out_maybe_d;
  logic [7:0]     mem [StoreBytes];

  logic           mod_start, mod_done;
  logic [RW-1:0]  mod_value, mod_rem;
  logic [KW-1:0]  mod_kstart;
  logic           we, rd_en;
  logic [BIW-1:0] waddr;
  logic [7:0]     wdata;

  bfrh_mod #(
    .MW(MW),
    .RW(RW),
    .KW(KW)
  ) u_mod (
    .clk_i,
    .rst_ni,
    .start_i (mod_start),
    .value_i (mod_value),
    .kstart_i(mod_kstart),
    .mod_i,
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    op_d        = op_q;
    renorm_d    = renorm_q;
    clr_cnt_d   = clr_cnt_q;
    idx_d       = idx_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    out_query_d = out_query_q;
    out_maybe_d = out_maybe_q;
    job_ready_o = 1'b0;
    mod_start   = 1'b0;
    mod_value   = RW'(hash_q);
    mod_kstart  = KW'(bfrh_pkg::StepsChar - 1);
    we          = 1'b0;
    rd_en       = 1'b0;
    waddr       = idx_q;
    wdata       = rd_q | (8'b1 << sel_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        wdata     = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == BIW'(StoreBytes - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (renorm_q) begin
          // bring the hash below a freshly written modulus
          mod_start  = 1'b1;
          mod_kstart = KW'(HW - 1);
          renorm_d   = 1'b0;
          state_d    = ST_RENORM;
        end else if (job_valid_i) begin
          job_ready_o = 1'b1;
          mod_start   = 1'b1;
          mod_value   = RW'(hash_q) * RW'(bfrh_pkg::HashMult) + RW'(job_i.char_code);
          op_d        = job_i.op;
          state_d     = ST_HASH;
        end
      end
      ST_RENORM: begin
        if (mod_done) begin
          hash_d  = mod_rem[HW-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          if (op_q == bfrh_pkg::OpChar) begin
            hash_d  = mod_rem[HW-1:0];
            state_d = ST_IDLE;
          end else begin
            hash_d  = '0;
            idx_d   = mod_rem[HW-1:3];
            sel_d   = mod_rem[2:0];
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          case (op_q)
            bfrh_pkg::OpQuery: begin
              out_query_d = 1'b1;
              out_maybe_d = rd_q[sel_q];
            end
            bfrh_pkg::OpInsert: begin
              out_query_d = 1'b0;
              out_maybe_d = 1'b0;
              we          = 1'b1;
            end
            default: begin
              out_query_d = 1'b0;
              out_maybe_d = 1'b0;
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (renorm_i) begin
      renorm_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      hash_q      <= '0;
      op_q        <= bfrh_pkg::OpChar;
      renorm_q    <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      op_q        <= op_d;
      renorm_q    <= renorm_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    sel_q       <= sel_d;
    out_query_q <= out_query_d;
    out_maybe_q <= out_maybe_d;
  end

  // bit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_query_o = out_query_q;
  assign out_maybe_o = out_maybe_q;

  `BFRH_ASSERT(a_rem_below_mod, ((state_q == ST_HASH) && mod_done) |-> (mod_rem < RW'(mod_i)), "hash not reduced below modulus")
  `BFRH_ASSERT(a_out_from_update, $rose(out_valid_q) |-> $past(state_q == ST_UPDATE), "result raised outside update")
  `BFRH_ASSERT(a_no_take_in_clear, (state_q == ST_CLEAR) |-> !job_ready_o, "request taken during clearing pass")
  `BFRH_ASSERT_NR(a_reset_state, !rst_ni |-> ((state_q == ST_CLEAR) && !out_valid_q), "reset did not restart clearing pass")

endmodule

`default_nettype wire
